>>> hw/rtl/bst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box scene sphere tracer package
// Shared constants, the box table entry type and the CORDIC angle table.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_BOXES_DEF = 8;
  localparam int MAX_STEPS_DEF = 40;

  // Field widths.
  localparam int COORD_W = 32;   // Q16.16 signed coordinate
  localparam int TRIG_W  = 16;   // Q2.14 signed cosine and sine
  localparam int LEN_W   = 31;   // Q15.16 unsigned extent or distance
  localparam int EPS_W   = 16;
  localparam int CNT_CFG_W = 4;
  localparam int HEAD_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Internal datapath widths.
  localparam int TIP_W  = 42;    // ray tip, room for 256 full-length steps
  localparam int PROD_W = TIP_W + TRIG_W;
  localparam int EXT_W  = 48;    // local coordinate and axis terms
  localparam int DIST_W = 33;    // signed box distance up to 2^31
  localparam int CORD_W = 34;    // CORDIC vector and angle
  localparam int MOVE_W = DIST_W + CORD_W;
  localparam int SQ_W   = 32;    // operand of a square
  localparam int RAD_W  = 64;    // radicand
  localparam int ROOT_W = 32;
  localparam int REM_W  = 35;

  localparam int CORDIC_STAGES = 16;
  localparam logic [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_COUNT    = 2'd2;

  // Input item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_TRACE = 1'b1;

  // One stored box.
  typedef struct packed {
    logic signed [TRIG_W-1:0]  cos_v;
    logic signed [TRIG_W-1:0]  sin_v;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
    logic [LEN_W-1:0]          length;
    logic [LEN_W-1:0]          width;
  } box_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/bst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box scene sphere tracer channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------

// Input items: box loads and ray traces.
interface bst_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [bst_pkg::SLOT_W-1:0]         box_slot;
  logic signed [bst_pkg::TRIG_W-1:0]  box_cos;
  logic signed [bst_pkg::TRIG_W-1:0]  box_sin;
  logic signed [bst_pkg::COORD_W-1:0] box_shift_x;
  logic signed [bst_pkg::COORD_W-1:0] box_shift_y;
  logic [bst_pkg::LEN_W-1:0]          box_length;
  logic [bst_pkg::LEN_W-1:0]          box_width;
  logic signed [bst_pkg::COORD_W-1:0] ray_start_x;
  logic signed [bst_pkg::COORD_W-1:0] ray_start_y;
  logic [bst_pkg::HEAD_W-1:0]         ray_heading;

  modport source (
    output valid, mode, box_slot, box_cos, box_sin, box_shift_x, box_shift_y,
           box_length, box_width, ray_start_x, ray_start_y, ray_heading,
    input  ready
  );
  modport sink (
    input  valid, mode, box_slot, box_cos, box_sin, box_shift_x, box_shift_y,
           box_length, box_width, ray_start_x, ray_start_y, ray_heading,
    output ready
  );
endinterface

// Results: one per traced ray.
interface bst_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [bst_pkg::LEN_W-1:0] range;

  modport source (output valid, hit, range, input ready);
  modport sink (input valid, hit, range, output ready);
endinterface

// Register writes.
interface bst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::CFG_IDX_W-1:0] reg_index;
  logic [bst_pkg::LEN_W-1:0]     data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

>>> hw/rtl/box_scene_sphere_tracer_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box scene sphere tracer
// Sphere traces a 2D ray against a table of oriented boxes held in memory.
// ----------------------------------------------------------------------------
// Sequencing: a load is written to the table on acceptance. A trace runs the
//   CORDIC stages, then visits each box per step, with a root when the tip is
//   outside it, and takes a last root for the range on a hit; one item is in
//   work at a time, paced by the shared bit-serial root and box table read port.
// Reset: rst_n (synchronous, active low) idles the sequencer, empties the
//   result register and restores the register defaults; the box table
//   keeps its contents.

module box_scene_sphere_tracer_2d #(
  parameter int MAX_BOXES = bst_pkg::MAX_BOXES_DEF,
  parameter int MAX_STEPS = bst_pkg::MAX_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bst_in_if.sink       in_chan,
  bst_out_if.source    out_chan,
  bst_cfg_if.sink      cfg_chan
);

  localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam int TIP_W  = bst_pkg::TIP_W;
  localparam int PROD_W = bst_pkg::PROD_W;
  localparam int EXT_W  = bst_pkg::EXT_W;
  localparam int DIST_W = bst_pkg::DIST_W;
  localparam int CORD_W = bst_pkg::CORD_W;
  localparam int MOVE_W = bst_pkg::MOVE_W;
  localparam int SQ_W   = bst_pkg::SQ_W;
  localparam int RAD_W  = bst_pkg::RAD_W;
  localparam int ROOT_W = bst_pkg::ROOT_W;
  localparam int REM_W  = bst_pkg::REM_W;
  localparam int LEN_W  = bst_pkg::LEN_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORD = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_LOC  = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_ROOT = 4'd8;
  localparam logic [3:0] S_BEST = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_ADV  = 4'd11;
  localparam logic [3:0] S_RNG  = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  // Root owner: a box distance or the final range.
  localparam logic CTX_BOX   = 1'b0;
  localparam logic CTX_RANGE = 1'b1;

  localparam logic [SQ_W-1:0]  DIST_SAT  = 32'h8000_0000;
  localparam logic [LEN_W-1:0] RANGE_MAX = 31'h7FFF_FFFF;

  // Control registers.
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [4:0]        it_r, it_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  max_dist_r;
  logic [bst_pkg::EPS_W-1:0]     eps_r;
  logic [bst_pkg::CNT_CFG_W-1:0] box_count_r;

  // Datapath registers.
  logic                     flip_r, flip_nxt;
  logic                     ctx_r, ctx_nxt;
  logic signed [CORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic signed [CORD_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [TIP_W-1:0]  tip_x_r, tip_x_nxt, tip_y_r, tip_y_nxt;
  logic signed [bst_pkg::COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [PROD_W-1:0] p_cx_r, p_sy_r, p_sx_r, p_cy_r;
  logic signed [EXT_W-1:0]  ex_r, ex_nxt, ey_r, ey_nxt;
  logic [SQ_W-1:0]          opa_r, opa_nxt, opb_r, opb_nxt;
  logic [RAD_W-1:0]         pa_r, pb_r;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic signed [DIST_W-1:0] bd_r, bd_nxt, best_r, best_nxt;
  logic signed [MOVE_W-1:0] mv_x_r, mv_y_r;
  logic                     res_hit_r, res_hit_nxt;
  logic [LEN_W-1:0]         res_range_r, res_range_nxt;
  logic                     out_hit_r;
  logic [LEN_W-1:0]         out_range_r;

  // Box table.
  bst_pkg::box_t mem [MAX_BOXES];
  bst_pkg::box_t mem_q;
  bst_pkg::box_t mem_wd;
  logic          mem_we;
  logic [IDX_W-1:0] mem_wa;

  logic in_xfer;
  logic [CNT_W-1:0] n_eff;

  // Combinational helpers.
  logic signed [CORD_W-1:0] xs, ys, ncx, ncy, ncz;
  logic signed [CORD_W-1:0] z_init;
  logic [31:0]              head_ang;
  logic signed [PROD_W:0]   dlx, dly;
  logic signed [EXT_W-1:0]  lx, ly, alx, aly;
  logic                     ex_pos, ey_pos;
  logic [SQ_W-1:0]          ox, oy;
  logic signed [EXT_W-1:0]  mx;
  logic [REM_W-1:0]         rem_sh, trial;
  logic signed [DIST_W-1:0] abs_best;
  logic signed [TIP_W-1:0]  ntx, nty, ofx, ofy, aofx, aofy;

  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.hit   = out_hit_r;
  assign out_chan.range = out_range_r;

  assign n_eff = (int'(box_count_r) > MAX_BOXES) ? CNT_W'(MAX_BOXES) : CNT_W'(box_count_r);

  // Table write port and registered read port.
  assign mem_we = in_xfer && (in_chan.mode == bst_pkg::MODE_LOAD) &&
                  (int'(in_chan.box_slot) < MAX_BOXES);
  assign mem_wa = IDX_W'(in_chan.box_slot);
  assign mem_wd = '{cos_v: in_chan.box_cos, sin_v: in_chan.box_sin,
                    shift_x: in_chan.box_shift_x, shift_y: in_chan.box_shift_y,
                    length: in_chan.box_length, width: in_chan.box_width};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[k_r[IDX_W-1:0]];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= LEN_W'(6553600);
      eps_r       <= 16'd655;
      box_count_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        bst_pkg::CFG_MAX_DISTANCE: max_dist_r  <= cfg_chan.data;
        bst_pkg::CFG_EPSILON:      eps_r       <= cfg_chan.data[bst_pkg::EPS_W-1:0];
        bst_pkg::CFG_BOX_COUNT:    box_count_r <= cfg_chan.data[bst_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Arithmetic for the current state.
  always_comb begin
    // CORDIC stage with floor shifts.
    xs  = cx_r >>> it_r[3:0];
    ys  = cy_r >>> it_r[3:0];
    if (!cz_r[CORD_W-1]) begin
      ncx = cx_r - ys;
      ncy = cy_r + xs;
      ncz = cz_r - CORD_W'(bst_pkg::atan_turn(it_r[3:0]));
    end else begin
      ncx = cx_r + ys;
      ncy = cy_r - xs;
      ncz = cz_r + CORD_W'(bst_pkg::atan_turn(it_r[3:0]));
    end
    head_ang = {in_chan.ray_heading, 16'h0};
    head_ang[31] = head_ang[31] ^ (in_chan.ray_heading[15] ^ in_chan.ray_heading[14]);
    z_init = CORD_W'($signed(head_ang));

    // Box local frame and axis terms.
    dlx = (PROD_W+1)'(p_cx_r) - (PROD_W+1)'(p_sy_r);
    dly = (PROD_W+1)'(p_sx_r) + (PROD_W+1)'(p_cy_r);
    lx  = EXT_W'(dlx >>> 14) + EXT_W'(mem_q.shift_x);
    ly  = EXT_W'(dly >>> 14) + EXT_W'(mem_q.shift_y);
    alx = lx[EXT_W-1] ? -lx : lx;
    aly = ly[EXT_W-1] ? -ly : ly;

    // Positive parts clamped at 2^31.
    ex_pos = !ex_r[EXT_W-1] && (ex_r != '0);
    ey_pos = !ey_r[EXT_W-1] && (ey_r != '0);
    ox = !ex_pos ? '0 : ($unsigned(ex_r) > EXT_W'(DIST_SAT)) ? DIST_SAT : ex_r[SQ_W-1:0];
    oy = !ey_pos ? '0 : ($unsigned(ey_r) > EXT_W'(DIST_SAT)) ? DIST_SAT : ey_r[SQ_W-1:0];
    mx = (ex_r > ey_r) ? ex_r : ey_r;

    // One root digit per cycle.
    rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, root_r, 2'b01};

    // Tip move and range offsets.
    abs_best = best_r[DIST_W-1] ? -best_r : best_r;
    ntx  = tip_x_r + TIP_W'(mv_x_r >>> 30);
    nty  = tip_y_r + TIP_W'(mv_y_r >>> 30);
    ofx  = tip_x_r - TIP_W'(sx_r);
    ofy  = tip_y_r - TIP_W'(sy_r);
    aofx = ofx[TIP_W-1] ? -ofx : ofx;
    aofy = ofy[TIP_W-1] ? -ofy : ofy;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    it_nxt        = it_r;
    flip_nxt      = flip_r;
    ctx_nxt       = ctx_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    tip_x_nxt     = tip_x_r;
    tip_y_nxt     = tip_y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    bd_nxt        = bd_r;
    best_nxt      = best_r;
    res_hit_nxt   = res_hit_r;
    res_range_nxt = res_range_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_chan.mode == bst_pkg::MODE_TRACE)) begin
          res_hit_nxt   = 1'b0;
          res_range_nxt = '0;
          sx_nxt        = in_chan.ray_start_x;
          sy_nxt        = in_chan.ray_start_y;
          flip_nxt      = in_chan.ray_heading[15] ^ in_chan.ray_heading[14];
          cx_nxt        = $signed(bst_pkg::CORDIC_GAIN);
          cy_nxt        = '0;
          cz_nxt        = z_init;
          it_nxt        = '0;
          state_nxt     = (n_eff == '0) ? S_EMIT : S_CORD;
        end
      end
      S_CORD: begin
        cx_nxt = ncx;
        cy_nxt = ncy;
        cz_nxt = ncz;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(bst_pkg::CORDIC_STAGES - 1)) begin
          dx_nxt    = flip_r ? -ncx : ncx;
          dy_nxt    = flip_r ? -ncy : ncy;
          tip_x_nxt = TIP_W'(sx_r);
          tip_y_nxt = TIP_W'(sy_r);
          step_nxt  = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      // The table read for box k is in flight.
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_LOC;
      S_LOC: begin
        ex_nxt    = alx - EXT_W'(mem_q.length[LEN_W-1:1]);
        ey_nxt    = aly - EXT_W'(mem_q.width[LEN_W-1:1]);
        state_nxt = S_DIST;
      end
      S_DIST: begin
        if (ex_pos || ey_pos) begin
          opa_nxt   = ox;
          opb_nxt   = oy;
          ctx_nxt   = CTX_BOX;
          state_nxt = S_SQ;
        end else begin
          bd_nxt    = mx[EXT_W-1] ? DIST_W'(mx) : '0;
          state_nxt = S_BEST;
        end
      end
      S_SQ: state_nxt = S_SUM;
      S_SUM: begin
        rad_nxt   = pa_r + pb_r;
        rem_nxt   = '0;
        root_nxt  = '0;
        it_nxt    = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        rad_nxt = rad_r << 2;
        it_nxt  = it_r + 5'd1;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (it_r == 5'd31) begin
          if (ctx_r == CTX_BOX) begin
            bd_nxt    = (root_nxt > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(root_nxt);
            state_nxt = S_BEST;
          end else begin
            res_hit_nxt   = 1'b1;
            res_range_nxt = (root_nxt > ROOT_W'(RANGE_MAX)) ? RANGE_MAX
                                                           : root_nxt[LEN_W-1:0];
            state_nxt     = S_EMIT;
          end
        end
      end
      // Keep the first minimum over the scene.
      S_BEST: begin
        if ((k_r == '0) || (bd_r < best_r)) begin
          best_nxt = bd_r;
        end
        if (CNT_W'(k_r + 1'b1) == n_eff) begin
          state_nxt = S_CHK;
        end else begin
          k_nxt     = CNT_W'(k_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_CHK: begin
        if (best_r > $signed({2'b00, max_dist_r})) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        tip_x_nxt = ntx;
        tip_y_nxt = nty;
        k_nxt     = '0;
        if (abs_best < $signed(DIST_W'(eps_r))) begin
          state_nxt = S_RNG;
        end else if (step_r == STEP_W'(MAX_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RNG: begin
        if ((aofx >= TIP_W'(DIST_SAT)) || (aofy >= TIP_W'(DIST_SAT))) begin
          res_hit_nxt   = 1'b1;
          res_range_nxt = RANGE_MAX;
          state_nxt     = S_EMIT;
        end else begin
          opa_nxt   = aofx[SQ_W-1:0];
          opb_nxt   = aofy[SQ_W-1:0];
          ctx_nxt   = CTX_RANGE;
          state_nxt = S_SQ;
        end
      end
      // Wait for the result register to free up.
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      step_r      <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers and multipliers.
  always_ff @(posedge clk) begin
    flip_r      <= flip_nxt;
    ctx_r       <= ctx_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    tip_x_r     <= tip_x_nxt;
    tip_y_r     <= tip_y_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    rad_r       <= rad_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    bd_r        <= bd_nxt;
    best_r      <= best_nxt;
    res_hit_r   <= res_hit_nxt;
    res_range_r <= res_range_nxt;
    p_cx_r      <= mem_q.cos_v * tip_x_r;
    p_sy_r      <= mem_q.sin_v * tip_y_r;
    p_sx_r      <= mem_q.sin_v * tip_x_r;
    p_cy_r      <= mem_q.cos_v * tip_y_r;
    pa_r        <= opa_r * opa_r;
    pb_r        <= opb_r * opb_r;
    mv_x_r      <= best_r * dx_r;
    mv_y_r      <= best_r * dy_r;
    if (state_r == S_EMIT && (!out_valid_r || out_chan.ready)) begin
      out_hit_r   <= res_hit_r;
      out_range_r <= res_range_r;
    end
  end

endmodule

>>> test/box_scene_sphere_tracer_2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box scene sphere tracer checker
// Watches the item, result and register channels. It keeps its own box
// table and registers, works out each ray's hit and range, and compares
// every result transfer against the oldest expected one.
// ----------------------------------------------------------------------------

module box_scene_sphere_tracer_2d_checker (
  input  logic clk,
  input  logic rst_n,
  bst_in_if    in_chan,
  bst_out_if   out_chan,
  bst_cfg_if   cfg_chan,
  output int   fail_count,
  output int   rays_in_flight
);

  localparam int NUM_BOXES  = bst_pkg::MAX_BOXES_DEF;
  localparam int NUM_STEPS  = bst_pkg::MAX_STEPS_DEF;
  localparam longint SAT_DIST  = 64'sd2147483648;
  localparam longint RANGE_TOP = 64'sd2147483647;
  localparam longint DIR_GAIN  = 64'sd652032874;

  typedef struct {
    logic                      hit;
    logic [bst_pkg::LEN_W-1:0] range;
  } ray_result_t;

  // Arctangent steps in units of 2^-32 turn.
  localparam longint ARC_STEP [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  longint      tbl_cos [NUM_BOXES];
  longint      tbl_sin [NUM_BOXES];
  longint      tbl_sx  [NUM_BOXES];
  longint      tbl_sy  [NUM_BOXES];
  longint      tbl_len [NUM_BOXES];
  longint      tbl_wid [NUM_BOXES];
  longint      miss_limit;
  longint      eps_limit;
  int unsigned scene_size;
  ray_result_t pending_rays [$];

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Signed distance from a point to one stored box.
  function automatic longint box_distance(int k, longint px, longint py);
    longint lx, ly, ex, ey, ox, oy, m;
    longint unsigned r;
    lx = ((tbl_cos[k] * px - tbl_sin[k] * py) >>> 14) + tbl_sx[k];
    ly = ((tbl_sin[k] * px + tbl_cos[k] * py) >>> 14) + tbl_sy[k];
    ex = mag(lx) - (tbl_len[k] >>> 1);
    ey = mag(ly) - (tbl_wid[k] >>> 1);
    ox = ex > 0 ? ex : 0;
    oy = ey > 0 ? ey : 0;
    if (ox > SAT_DIST) ox = SAT_DIST;
    if (oy > SAT_DIST) oy = SAT_DIST;
    if (ox > 0 || oy > 0) begin
      r = int_root(longint'(ox * ox) + longint'(oy * oy));
      return r > SAT_DIST ? SAT_DIST : longint'(r);
    end
    m = ex > ey ? ex : ey;
    return m < 0 ? m : 0;
  endfunction

  // March one ray through the scene.
  function automatic ray_result_t trace_ray(longint sx0, longint sy0, logic [15:0] hd);
    ray_result_t res;
    int          n;
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys, dx, dy, tx, ty, d, best, ox, oy;
    longint unsigned r;
    res.hit = 1'b0;
    res.range = '0;
    n = scene_size > NUM_BOXES ? NUM_BOXES : scene_size;
    if (n == 0) return res;
    a = {hd, 16'h0};
    flip = (hd[15:14] == 2'd1) || (hd[15:14] == 2'd2);
    if (flip) a = a + 32'h80000000;
    z = a < 32'h80000000 ? longint'(a) : longint'(a) - 64'sd4294967296;
    x = DIR_GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARC_STEP[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARC_STEP[i];
      end
    end
    dx = flip ? -x : x;
    dy = flip ? -y : y;
    tx = sx0;
    ty = sy0;
    for (int step = 0; step < NUM_STEPS; step++) begin
      best = box_distance(0, tx, ty);
      for (int k = 1; k < n; k++) begin
        d = box_distance(k, tx, ty);
        if (d < best) best = d;
      end
      if (best > miss_limit) return res;
      tx = tx + ((best * dx) >>> 30);
      ty = ty + ((best * dy) >>> 30);
      if (mag(best) < eps_limit) begin
        ox = mag(tx - sx0);
        oy = mag(ty - sy0);
        r = RANGE_TOP;
        if (ox < SAT_DIST && oy < SAT_DIST) begin
          r = int_root(longint'(ox * ox) + longint'(oy * oy));
          if (r > RANGE_TOP) r = RANGE_TOP;
        end
        res.hit = 1'b1;
        res.range = r[bst_pkg::LEN_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  assign rays_in_flight = pending_rays.size();

  // Track register writes, box loads and traces; check results.
  always @(posedge clk) begin
    ray_result_t want;
    if (!rst_n) begin
      miss_limit <= 64'sd6553600;
      eps_limit <= 64'sd655;
      scene_size <= 0;
      pending_rays.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.reg_index)
          bst_pkg::CFG_MAX_DISTANCE: miss_limit <= longint'(cfg_chan.data);
          bst_pkg::CFG_EPSILON:
            eps_limit <= longint'(cfg_chan.data[bst_pkg::EPS_W-1:0]);
          bst_pkg::CFG_BOX_COUNT:
            scene_size <= 32'(cfg_chan.data[bst_pkg::CNT_CFG_W-1:0]);
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.mode == bst_pkg::MODE_LOAD) begin
          tbl_cos[in_chan.box_slot] = longint'(in_chan.box_cos);
          tbl_sin[in_chan.box_slot] = longint'(in_chan.box_sin);
          tbl_sx[in_chan.box_slot]  = longint'(in_chan.box_shift_x);
          tbl_sy[in_chan.box_slot]  = longint'(in_chan.box_shift_y);
          tbl_len[in_chan.box_slot] = longint'(in_chan.box_length);
          tbl_wid[in_chan.box_slot] = longint'(in_chan.box_width);
        end else begin
          pending_rays.push_back(trace_ray(longint'(in_chan.ray_start_x),
                                           longint'(in_chan.ray_start_y),
                                           in_chan.ray_heading));
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_rays.size() == 0) begin
          $error("result transfer with no ray outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = pending_rays.pop_front();
          if (out_chan.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_chan.hit);
            fail_count <= fail_count + 1;
          end else if (out_chan.range !== want.range) begin
            $error("range: expected %0d, actual %0d", want.range, out_chan.range);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

>>> test/box_scene_sphere_tracer_2d_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box scene sphere tracer testbench
// Loads boxes and casts rays through several register settings, directed
// cases first and then random scenes, with random gaps on both channels.
// The checker predicts and compares; this module drives and decides.
// ----------------------------------------------------------------------------

module box_scene_sphere_tracer_2d_test;

  localparam int  STALL_LIMIT = 200000;
  localparam int  SETTLE      = 60;
  localparam int  PHASE_ITEMS = 195;
  localparam logic [30:0] UNIT = 31'd65536;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   rays_in_flight;
  int   quiet_cycles;
  int   hold_cycles;
  logic idle_off;

  bst_in_if  in_chan ();
  bst_out_if out_chan ();
  bst_cfg_if cfg_chan ();

  box_scene_sphere_tracer_2d i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  box_scene_sphere_tracer_2d_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .cfg_chan       (cfg_chan),
    .fail_count     (fail_count),
    .rays_in_flight (rays_in_flight)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (idle_off || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Result side stalls at random, mostly briefly and now and then for long.
  always @(posedge clk) begin
    if (idle_off) begin
      out_chan.ready <= 1'b1;
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      out_chan.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 99) < 1) begin
      out_chan.ready <= 1'b0;
      hold_cycles <= $urandom_range(15, 60);
    end else if ($urandom_range(0, 99) < 3) begin
      out_chan.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** box_scene_sphere_tracer_2d: FAILED **");
      $finish;
    end
  end

  task automatic wait_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_box(logic [2:0] slot, logic signed [15:0] c, logic signed [15:0] s,
                          logic signed [31:0] tx, logic signed [31:0] ty,
                          logic [30:0] len, logic [30:0] wid);
    in_chan.valid <= 1'b1;
    in_chan.mode <= bst_pkg::MODE_LOAD;
    in_chan.box_slot <= slot;
    in_chan.box_cos <= c;
    in_chan.box_sin <= s;
    in_chan.box_shift_x <= tx;
    in_chan.box_shift_y <= ty;
    in_chan.box_length <= len;
    in_chan.box_width <= wid;
    in_chan.ray_start_x <= $urandom;
    in_chan.ray_start_y <= $urandom;
    in_chan.ray_heading <= 16'($urandom);
    do @(posedge clk); while (!in_chan.ready);
    wait_gap();
  endtask

  task automatic cast_ray(logic signed [31:0] sx, logic signed [31:0] sy, logic [15:0] hd);
    in_chan.valid <= 1'b1;
    in_chan.mode <= bst_pkg::MODE_TRACE;
    in_chan.box_slot <= 3'($urandom);
    in_chan.box_cos <= 16'($urandom);
    in_chan.box_sin <= 16'($urandom);
    in_chan.box_shift_x <= $urandom;
    in_chan.box_shift_y <= $urandom;
    in_chan.box_length <= 31'($urandom);
    in_chan.box_width <= 31'($urandom);
    in_chan.ray_start_x <= sx;
    in_chan.ray_start_y <= sy;
    in_chan.ray_heading <= hd;
    do @(posedge clk); while (!in_chan.ready);
    wait_gap();
  endtask

  // Lets the block drain before registers change. The first edge lets the
  // checker record an item accepted at the edge just passed.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (rays_in_flight != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [bst_pkg::CFG_IDX_W-1:0] idx, logic [30:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.data <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_scene(logic [30:0] far, logic [30:0] eps, logic [30:0] count);
    drain();
    write_reg(bst_pkg::CFG_MAX_DISTANCE, far);
    write_reg(bst_pkg::CFG_EPSILON, eps);
    write_reg(bst_pkg::CFG_BOX_COUNT, count);
  endtask

  function automatic logic signed [31:0] near_coord(int units);
    return $signed($urandom_range(0, 2 * units * 65536)) - units * 65536;
  endfunction

  // Mostly plausible boxes and rays near the origin, some full-range noise.
  task automatic random_phase(int items, logic pause_mid);
    int sel;
    for (int i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) drain();
      sel = $urandom_range(0, 99);
      if (sel < 25)
        load_box(3'($urandom), 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 near_coord(20), near_coord(20),
                 31'($urandom_range(UNIT, 20 * UNIT)),
                 31'($urandom_range(UNIT, 20 * UNIT)));
      else if (sel < 30)
        load_box(3'($urandom), 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 $urandom, $urandom, 31'($urandom), 31'($urandom));
      else if (sel < 92)
        cast_ray(near_coord(30), near_coord(30), 16'($urandom));
      else
        cast_ray($urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_off = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.mode = bst_pkg::MODE_LOAD;
    in_chan.box_slot = '0;
    in_chan.box_cos = '0;
    in_chan.box_sin = '0;
    in_chan.box_shift_x = '0;
    in_chan.box_shift_y = '0;
    in_chan.box_length = '0;
    in_chan.box_width = '0;
    in_chan.ray_start_x = '0;
    in_chan.ray_start_y = '0;
    in_chan.ray_heading = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.reg_index = bst_pkg::CFG_MAX_DISTANCE;
    cfg_chan.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty scene after reset: a miss.
    cast_ray(0, 0, 16'h0000);
    // Fill every slot before any scene reads it.
    load_box(3'd0, 16'sd16384, 16'sd0, 0, 0, 31'(4 * UNIT), 31'(2 * UNIT));
    load_box(3'd1, 16'sd0, 16'sd16384, -10 * 65536, 5 * 65536,
             31'(2 * UNIT), 31'(2 * UNIT));
    load_box(3'd2, -16'sd16384, 16'sd0, 32'sh7FFFFFFF, 32'sh80000000,
             31'h7FFFFFFF, 31'd0);
    load_box(3'd3, 16'sd0, -16'sd16384, 32'sh80000000, 32'sh7FFFFFFF,
             31'd0, 31'h7FFFFFFF);
    load_box(3'd4, 16'sd11585, 16'sd11585, 20 * 65536, 0, 31'(6 * UNIT), UNIT);
    load_box(3'd5, 16'sd11585, -16'sd11585, 0, -20 * 65536, UNIT, 31'(6 * UNIT));
    load_box(3'd6, 16'sd16384, 16'sd0, 8 * 65536, 8 * 65536,
             31'(3 * UNIT), 31'(3 * UNIT));
    load_box(3'd7, 16'sd16384, 16'sd0, -8 * 65536, -8 * 65536,
             31'(3 * UNIT), 31'(3 * UNIT));

    // One box: rays along each axis, one starting inside the box.
    set_scene(31'd6553600, 31'd655, 31'd1);
    cast_ray(-10 * 65536, 0, 16'h0000);
    cast_ray(10 * 65536, 0, 16'h4000);
    cast_ray(10 * 65536, 0, 16'h8000);
    cast_ray(0, 10 * 65536, 16'hC000);
    cast_ray(0, 0, 16'hFFFF);
    cast_ray(32'sh7FFFFFFF, 32'sh80000000, 16'h2000);

    // Widest thresholds, count above the table size.
    set_scene(31'h7FFFFFFF, 31'd65535, 31'd15);
    cast_ray(32'sh80000000, 32'sh80000000, 16'h2000);
    cast_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hA000);
    cast_ray(0, 0, 16'h6000);

    // Zero thresholds: everything misses or runs out of steps.
    set_scene(31'd0, 31'd0, 31'd8);
    cast_ray(0, 0, 16'h1234);
    cast_ray(-30 * 65536, 3 * 65536, 16'h0000);

    // Random phases through several settings.
    set_scene(31'd6553600, 31'd655, 31'd1);
    random_phase(PHASE_ITEMS, 1'b1);
    set_scene(31'd3276800, 31'd4000, 31'd2);
    idle_off = 1'b1;
    random_phase(PHASE_ITEMS, 1'b0);
    idle_off = 1'b0;
    set_scene(31'h7FFFFFFF, 31'd65535, 31'd3);
    random_phase(PHASE_ITEMS, 1'b0);
    set_scene(31'($urandom), 31'($urandom_range(0, 65535)),
              31'($urandom_range(9, 15)) | 31'h7FFFFFF0);
    random_phase(PHASE_ITEMS, 1'b0);
    set_scene(31'd13107200, 31'd1000, 31'd4);
    random_phase(PHASE_ITEMS, 1'b0);
    set_scene(31'd0, 31'd0, 31'd0);
    random_phase(PHASE_ITEMS / 2, 1'b0);
    set_scene(31'd6553600, 31'd2000, 31'd8);
    random_phase(PHASE_ITEMS / 2, 1'b0);

    // Let the last results come out.
    drain();
    if (fail_count == 0 && rays_in_flight == 0) begin
      $display("** box_scene_sphere_tracer_2d: PASSED **");
    end else begin
      $display("** box_scene_sphere_tracer_2d: FAILED **");
    end
    $finish;
  end

endmodule
